### rtl/jdm_pkg.sv
// shared types and constants for the joystick differential mixer
package jdm_pkg;

    // default stick sample width, Q1.(bits-1)
    localparam int JDM_SAMPLE_BITS = 16;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MUL_X,
        ST_MUL_Y,
        ST_CMP,
        ST_MAG,
        ST_SQRT,
        ST_RN,
        ST_DIV,
        ST_MD_START,
        ST_MD_A,
        ST_MD_B,
        ST_FINAL,
        ST_OUTPUT
    } jdm_state_t;

endpackage

### rtl/jdm_subcmp.sv
// shared subtract and compare unit used by every iterative step
module jdm_subcmp
    import jdm_pkg::*;
#(
    parameter int WIDTH = 2 * JDM_SAMPLE_BITS + 1
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             ge
);

    logic borrow;

    // single subtract, the borrow gives the compare
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

### rtl/joystick_differential_mixer_top.sv
// joystick differential mixer: stick store, sequencer and iterative datapath
// An accepted word goes straight from classification to output when an axis is in the dead zone,
// otherwise it runs at most a sqrt of SAMPLE_BITS steps,
// radius rescale of SAMPLE_BITS-1 steps and cosine scaling of one or two steps per radius bit,
// all on the one shared subtract/compare unit; a new word is taken only back in ST_IDLE.
// Reset (aresetn, synchronous, active low) clears both stick positions, the dead zone
// and the sequencer at once; a finished result waiting on m_ready does not block the next word.
module joystick_differential_mixer_top
    import jdm_pkg::*;
#(
    parameter int SAMPLE_BITS = JDM_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [SAMPLE_BITS-2:0]        cfg_wr_data,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [SAMPLE_BITS-1:0] s_axis_value,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_drive,
    output logic signed [SAMPLE_BITS-1:0] m_right_drive
);

    localparam int W  = SAMPLE_BITS;
    localparam int UW = 2 * W + 1;
    localparam int CW = $clog2(W);
    localparam logic [W-1:0] ONE_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W:0] MAX_V = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0] MIN_V = {2'b11, {(W-1){1'b0}}};

    jdm_state_t state_reg, state_next;

    logic signed [W-1:0] stick_x_reg, stick_x_next;
    logic signed [W-1:0] stick_y_reg, stick_y_next;
    logic [W-2:0]        dead_zone_reg;
    logic [W-1:0]        ax_reg, ax_next;
    logic [W-1:0]        ay_reg, ay_next;
    logic [2*W-1:0]      xx_reg, xx_next;
    logic [2*W-1:0]      yy_reg, yy_next;
    logic [2*W-1:0]      r2_reg, r2_next;
    logic [2*W-1:0]      mag_reg, mag_next;
    logic                ygex_reg, ygex_next;
    logic [UW-1:0]       rem_reg, rem_next;
    logic [W-1:0]        root_reg, root_next;
    logic [2*W-1:0]      sq_src_reg, sq_src_next;
    logic [W-1:0]        q_reg, q_next;
    logic [W-1:0]        rn_reg, rn_next;
    logic [W-1:0]        div_d_reg, div_d_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic signed [W-1:0] res_left_reg, res_left_next;
    logic signed [W-1:0] res_right_reg, res_right_next;
    logic                m_valid_reg, m_valid_next;
    logic signed [W-1:0] m_left_reg, m_left_next;
    logic signed [W-1:0] m_right_reg, m_right_next;

    logic [W-1:0]        abs_x, abs_y;
    logic                dead_x, dead_y;
    logic signed [W:0]   x_ext, y_ext, neg_x, neg_y;
    logic signed [W:0]   rs, rc_pos, rc, neg_rs, neg_rc;
    logic                x_neg, x_zero, y_neg, y_zero;
    logic [W-1:0]        mul_op;
    logic [2*W-1:0]      prod;
    logic [UW-1:0]       alu_a, alu_b, alu_diff;
    logic                alu_ge;

    // clamp to the signed sample range
    function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
        logic signed [W:0] t;
        t = v;
        if (v > MAX_V) begin
            t = MAX_V;
        end else if (v < MIN_V) begin
            t = MIN_V;
        end
        return t[W-1:0];
    endfunction

    // shared arithmetic unit
    jdm_subcmp #(
        .WIDTH (UW)
    ) u_subcmp (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // one squaring multiplier, reused for both axes
    assign prod = (2*W)'(mul_op) * (2*W)'(mul_op);

    // axis magnitudes and dead zone tests
    assign abs_x  = stick_x_reg[W-1] ? (~stick_x_reg + W'(1)) : stick_x_reg;
    assign abs_y  = stick_y_reg[W-1] ? (~stick_y_reg + W'(1)) : stick_y_reg;
    assign dead_x = abs_x < {1'b0, dead_zone_reg};
    assign dead_y = abs_y < {1'b0, dead_zone_reg};
    assign x_ext  = {stick_x_reg[W-1], stick_x_reg};
    assign y_ext  = {stick_y_reg[W-1], stick_y_reg};
    assign neg_x  = -x_ext;
    assign neg_y  = -y_ext;

    // quadrant flags and signed radius and cosine terms
    assign x_neg  = stick_x_reg[W-1];
    assign y_neg  = stick_y_reg[W-1];
    assign x_zero = (stick_x_reg == '0);
    assign y_zero = (stick_y_reg == '0);
    assign rs     = {1'b0, rn_reg};
    assign rc_pos = {1'b0, q_reg};
    assign rc     = ygex_reg ? rc_pos : -rc_pos;
    assign neg_rs = -rs;
    assign neg_rc = -rc;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_left_drive  = m_left_reg;
    assign m_right_drive = m_right_reg;

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            stick_x_reg   <= '0;
            stick_y_reg   <= '0;
            dead_zone_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            stick_x_reg <= stick_x_next;
            stick_y_reg <= stick_y_next;
            if (cfg_wr_en) begin
                dead_zone_reg <= cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        xx_reg        <= xx_next;
        yy_reg        <= yy_next;
        r2_reg        <= r2_next;
        mag_reg       <= mag_next;
        ygex_reg      <= ygex_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        sq_src_reg    <= sq_src_next;
        q_reg         <= q_next;
        rn_reg        <= rn_next;
        div_d_reg     <= div_d_next;
        cnt_reg       <= cnt_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        m_left_reg    <= m_left_next;
        m_right_reg   <= m_right_next;
    end

    // sequencer: next state, unit operands and datapath updates
    always_comb begin
        state_next     = state_reg;
        stick_x_next   = stick_x_reg;
        stick_y_next   = stick_y_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        r2_next        = r2_reg;
        mag_next       = mag_reg;
        ygex_next      = ygex_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        sq_src_next    = sq_src_reg;
        q_next         = q_reg;
        rn_next        = rn_reg;
        div_d_next     = div_d_reg;
        cnt_next       = cnt_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        m_left_next    = m_left_reg;
        m_right_next   = m_right_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mul_op         = ax_reg;
        alu_a          = '0;
        alu_b          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op) begin
                        stick_x_next = s_axis_value;
                    end else begin
                        stick_y_next = s_axis_value;
                    end
                    state_next = ST_CLASSIFY;
                end
            end

            // dead zone cases finish here
            ST_CLASSIFY: begin
                ax_next = abs_x;
                ay_next = abs_y;
                if (dead_x && dead_y) begin
                    res_left_next  = '0;
                    res_right_next = '0;
                    state_next     = ST_OUTPUT;
                end else if (dead_x) begin
                    res_left_next  = sat(neg_y);
                    res_right_next = sat(neg_y);
                    state_next     = ST_OUTPUT;
                end else if (dead_y) begin
                    res_left_next  = sat(x_ext);
                    res_right_next = sat(neg_x);
                    state_next     = ST_OUTPUT;
                end else begin
                    state_next = ST_MUL_X;
                end
            end

            ST_MUL_X: begin
                mul_op     = ax_reg;
                xx_next    = prod;
                state_next = ST_MUL_Y;
            end

            ST_MUL_Y: begin
                mul_op     = ay_reg;
                yy_next    = prod;
                state_next = ST_CMP;
            end

            // sign of y^2 - x^2 and the squared radius
            ST_CMP: begin
                alu_a      = {1'b0, yy_reg};
                alu_b      = {1'b0, xx_reg};
                ygex_next  = alu_ge;
                r2_next    = xx_reg + yy_reg;
                state_next = ST_MAG;
            end

            // |y^2 - x^2|, then set up the root
            ST_MAG: begin
                alu_a       = ygex_reg ? {1'b0, yy_reg} : {1'b0, xx_reg};
                alu_b       = ygex_reg ? {1'b0, xx_reg} : {1'b0, yy_reg};
                mag_next    = alu_diff[2*W-1:0];
                rem_next    = '0;
                root_next   = '0;
                sq_src_next = r2_reg;
                cnt_next    = CW'(W - 1);
                state_next  = ST_SQRT;
            end

            // one root bit per cycle
            ST_SQRT: begin
                alu_a       = {rem_reg[UW-3:0], sq_src_reg[2*W-1 -: 2]};
                alu_b       = {{(UW-W-2){1'b0}}, root_reg, 2'b01};
                rem_next    = alu_ge ? alu_diff : alu_a;
                root_next   = {root_reg[W-2:0], alu_ge};
                sq_src_next = {sq_src_reg[2*W-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    state_next = ST_RN;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            // clamp or start the dead zone rescale
            ST_RN: begin
                alu_a      = {{(UW-W){1'b0}}, root_reg};
                alu_b      = {{(UW-W+1){1'b0}}, dead_zone_reg};
                div_d_next = ONE_W - {1'b0, dead_zone_reg};
                if (root_reg[W-1]) begin
                    rn_next    = ONE_W;
                    state_next = ST_MD_START;
                end else if (!alu_ge) begin
                    rn_next    = '0;
                    state_next = ST_MD_START;
                end else begin
                    rem_next   = alu_diff;
                    q_next     = '0;
                    cnt_next   = CW'(W - 2);
                    state_next = ST_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV: begin
                alu_a    = {rem_reg[UW-2:0], 1'b0};
                alu_b    = {{(UW-W){1'b0}}, div_d_reg};
                rem_next = alu_ge ? alu_diff : alu_a;
                q_next   = {q_reg[W-2:0], alu_ge};
                if (cnt_reg == '0) begin
                    rn_next    = {q_reg[W-2:0], alu_ge};
                    state_next = ST_MD_START;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            ST_MD_START: begin
                rem_next = '0;
                q_next   = '0;
                cnt_next = CW'(W - 1);
                if (r2_reg == '0) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_MD_A;
                end
            end

            // radius times magnitude over r^2: doubling step
            ST_MD_A: begin
                alu_a    = {rem_reg[UW-2:0], 1'b0};
                alu_b    = {1'b0, r2_reg};
                rem_next = alu_ge ? alu_diff : alu_a;
                q_next   = {q_reg[W-2:0], alu_ge};
                if (rn_reg[cnt_reg]) begin
                    state_next = ST_MD_B;
                end else if (cnt_reg == '0) begin
                    state_next = ST_FINAL;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            // add step for a set radius bit
            ST_MD_B: begin
                alu_a    = rem_reg + {1'b0, mag_reg};
                alu_b    = {1'b0, r2_reg};
                rem_next = alu_ge ? alu_diff : alu_a;
                q_next   = q_reg + W'(alu_ge);
                if (cnt_reg == '0) begin
                    state_next = ST_FINAL;
                end else begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_MD_A;
                end
            end

            // quadrant mapping
            ST_FINAL: begin
                if (!x_neg && y_neg) begin
                    res_left_next  = sat(rs);
                    res_right_next = sat(rc);
                end else if (!x_neg && !x_zero && !y_neg) begin
                    res_left_next  = sat(neg_rc);
                    res_right_next = sat(neg_rs);
                end else if (x_neg && (y_neg || y_zero)) begin
                    res_left_next  = sat(rc);
                    res_right_next = sat(rs);
                end else begin
                    res_left_next  = sat(neg_rs);
                    res_right_next = sat(neg_rc);
                end
                state_next = ST_OUTPUT;
            end

            // hand the word to the output register once it is free
            ST_OUTPUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_left_next  = res_left_reg;
                    m_right_next = res_right_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a new result appears only from the output state
    a_valid_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUTPUT))
        else $error("result valid rose outside the output state");

    // division remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {{(UW-W){1'b0}}, div_d_reg}))
        else $error("division remainder out of range");

    // scaling remainder stays below r^2
    a_md_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MD_A || state_reg == ST_MD_B) |-> (rem_reg < {1'b0, r2_reg}))
        else $error("scaling remainder out of range");

    // cosine term never exceeds the radius
    a_cos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |-> (q_reg <= rn_reg))
        else $error("cosine term larger than radius");
`endif

endmodule
